// File: hw/rtl/assert_macros.svh
// Assertion macros for the RTL of the LFU tag table, included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/lfu_pkg.sv
// Package with sizes, payload types and register codes of the LFU tag table.
package lfu_pkg;

  localparam int DEPTH   = 64;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int OCC_W   = $clog2(DEPTH + 1);
  localparam int KEY_W   = 64;
  localparam int COUNT_W = 16;
  localparam int STAMP_W = 48;
  localparam int SLOT_W  = 6;
  localparam int OCCF_W  = 7;
  localparam int MAXE_W  = 7;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  localparam logic [ADDR_W-1:0]  ADDR_MAX_ENTRIES = 3'd0;
  localparam logic [MAXE_W-1:0]  MAX_ENTRIES_RST  = 7'd64;
  localparam logic [COUNT_W-1:0] COUNT_MAX        = '1;
  localparam logic [COUNT_W-1:0] COUNT_INIT       = 16'd1;

  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_INSERT = 1'b1;

  typedef struct packed {
    logic             action;
    logic [KEY_W-1:0] key;
  } in_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              evicted;
    logic [SLOT_W-1:0] victim_slot;
    logic [OCCF_W-1:0] occupancy;
  } out_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [COUNT_W-1:0] count;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic               m_found;
    logic [IDX_W-1:0]   m_idx;
    logic [COUNT_W-1:0] m_count;
    logic               v_found;
    logic [IDX_W-1:0]   v_idx;
    logic               f_found;
    logic [IDX_W-1:0]   f_idx;
  } scan_res_t;

endpackage

// File: hw/rtl/lfu_cache_table_policy.sv
// Top level of the LFU tag table: sequencer, valid bits, counters and ports.
// A result is loaded into the output register in the write state, after the entry walk and the
// drain state; the write waits while a held result is stalled. The walk makes one memory read per cycle.
// A new transaction is accepted once the previous result is loaded into the output register.
// Reset is synchronous, active low: all entries invalid, stamp and occupancy zero,
// max_entries 64. There is no clearing pass.
`include "assert_macros.svh"

module lfu_cache_table_policy (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  lfu_pkg::in_t               in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output lfu_pkg::out_t              out_data,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lfu_pkg::ADDR_W-1:0] paddr,
  input  logic [lfu_pkg::DATA_W-1:0] pwdata,
  output logic [lfu_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_WRITE = 2'd3;

  localparam logic [lfu_pkg::IDX_W-1:0] LAST_IDX = lfu_pkg::IDX_W'(lfu_pkg::DEPTH - 1);
  localparam logic [lfu_pkg::OCC_W-1:0] FULL_OCC = lfu_pkg::OCC_W'(lfu_pkg::DEPTH);

  logic [1:0]                  state_r, state_nxt;
  logic [lfu_pkg::IDX_W-1:0]   cnt_r, cnt_nxt;
  logic                        p_en_r;
  logic [lfu_pkg::IDX_W-1:0]   p_idx_r;
  logic                        p_vld_r;
  lfu_pkg::in_t                item_r;
  logic                        do_evict_r;
  logic [lfu_pkg::DEPTH-1:0]   valid_r, valid_nxt;
  logic [lfu_pkg::OCC_W-1:0]   total_r, total_nxt;
  logic [lfu_pkg::STAMP_W-1:0] stamp_r;
  logic [lfu_pkg::MAXE_W-1:0]  max_entries_r;
  logic                        out_valid_r;
  lfu_pkg::out_t               out_data_r;

  logic                        accept;
  logic                        commit;
  logic                        cfg_wr;
  logic                        is_ins;
  logic                        ev;
  logic                        m_ok;
  logic                        grow;
  logic [lfu_pkg::IDX_W-1:0]   ins_slot;
  logic [lfu_pkg::IDX_W-1:0]   wr_slot;
  logic                        we;
  lfu_pkg::entry_t             wdata;
  lfu_pkg::entry_t             rdata;
  lfu_pkg::scan_res_t          sr;
  lfu_pkg::out_t               res;
  logic [lfu_pkg::COUNT_W-1:0] hit_count;
  logic [lfu_pkg::OCC_W-1:0]   max_ext;
  logic                        need_evict;
  logic [lfu_pkg::OCC_W-1:0]   valid_cnt;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign commit   = (state_r == ST_WRITE) && !(out_valid_r && out_stall);
  assign cfg_wr   = psel && penable && pwrite && (paddr == lfu_pkg::ADDR_MAX_ENTRIES);
  assign pready   = 1'b1;

  always_comb begin
    if (paddr == lfu_pkg::ADDR_MAX_ENTRIES) begin
      prdata = lfu_pkg::DATA_W'(max_entries_r);
    end else begin
      prdata = '0;
    end
  end

  assign max_ext    = lfu_pkg::OCC_W'(max_entries_r);
  assign need_evict = (total_r != '0) && ((total_r >= max_ext) || (total_r >= FULL_OCC));
  assign valid_cnt  = lfu_pkg::OCC_W'($countones(valid_r));

  lfu_tbl_mem u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (wr_slot),
    .wdata (wdata),
    .raddr (cnt_r),
    .rdata (rdata)
  );

  lfu_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (accept),
    .en    (p_en_r),
    .idx   (p_idx_r),
    .vld   (p_vld_r),
    .ent   (rdata),
    .key   (item_r.key),
    .res   (sr)
  );

  always_comb begin
    is_ins = (item_r.action == lfu_pkg::ACT_INSERT);
    ev     = is_ins && do_evict_r && sr.v_found;
    m_ok   = sr.m_found && !(ev && (sr.m_idx == sr.v_idx));
    grow   = !m_ok && (ev || sr.f_found);
    if (m_ok) begin
      ins_slot = sr.m_idx;
    end else if (ev) begin
      ins_slot = (sr.f_found && (sr.f_idx < sr.v_idx)) ? sr.f_idx : sr.v_idx;
    end else if (sr.f_found) begin
      ins_slot = sr.f_idx;
    end else begin
      ins_slot = '0;
    end
    hit_count = (sr.m_count == lfu_pkg::COUNT_MAX) ? sr.m_count
                                                   : sr.m_count + lfu_pkg::COUNT_W'(1);
    wr_slot     = is_ins ? ins_slot : sr.m_idx;
    we          = commit && (is_ins || sr.m_found);
    wdata.key   = item_r.key;
    wdata.count = is_ins ? lfu_pkg::COUNT_INIT : hit_count;
    wdata.stamp = stamp_r;
    if (is_ins) begin
      total_nxt = total_r - lfu_pkg::OCC_W'(ev) + lfu_pkg::OCC_W'(grow);
    end else begin
      total_nxt = total_r;
    end
    valid_nxt = valid_r;
    if (ev) begin
      valid_nxt[sr.v_idx] = 1'b0;
    end
    if (is_ins) begin
      valid_nxt[ins_slot] = 1'b1;
    end
    res.hit         = !is_ins && sr.m_found;
    res.slot        = (is_ins || sr.m_found) ? lfu_pkg::SLOT_W'(wr_slot) : '0;
    res.evicted     = ev;
    res.victim_slot = ev ? lfu_pkg::SLOT_W'(sr.v_idx) : '0;
    res.occupancy   = lfu_pkg::OCCF_W'(total_nxt);
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (accept) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cnt_nxt = cnt_r + lfu_pkg::IDX_W'(1);
        if (cnt_r == LAST_IDX) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        if (commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      cnt_r         <= '0;
      p_en_r        <= 1'b0;
      valid_r       <= '0;
      total_r       <= '0;
      stamp_r       <= '0;
      max_entries_r <= lfu_pkg::MAX_ENTRIES_RST;
      out_valid_r   <= 1'b0;
      do_evict_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      p_en_r  <= (state_r == ST_SCAN);
      if (cfg_wr) begin
        max_entries_r <= pwdata[lfu_pkg::MAXE_W-1:0];
      end
      if (accept) begin
        do_evict_r <= need_evict;
      end
      if (commit) begin
        total_r <= total_nxt;
        valid_r <= valid_nxt;
        if (is_ins || sr.m_found) begin
          stamp_r <= stamp_r + lfu_pkg::STAMP_W'(1);
        end
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    p_idx_r <= cnt_r;
    p_vld_r <= valid_r[cnt_r];
    if (accept) begin
      item_r <= in_data;
    end
    if (commit) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_CLK(a_occ_range, total_r <= FULL_OCC, "Occupancy exceeds the table depth.")
  `ASSERT_CLK(a_occ_count, total_r == valid_cnt, "Occupancy disagrees with the valid bits.")
  `ASSERT_NEXT(a_acc_scan, accept, state_r == ST_SCAN, "Accepted item did not start the walk.")
  `ASSERT_CLK(a_vic_valid, (commit && ev) |-> valid_r[sr.v_idx], "Victim is not a valid entry.")

endmodule

// File: hw/rtl/lfu_tbl_mem.sv
// Entry memory of the tag table with one write port and one registered read port.
module lfu_tbl_mem (
  input  logic                      clk,
  input  logic                      we,
  input  logic [lfu_pkg::IDX_W-1:0] waddr,
  input  lfu_pkg::entry_t           wdata,
  input  logic [lfu_pkg::IDX_W-1:0] raddr,
  output lfu_pkg::entry_t           rdata
);

  lfu_pkg::entry_t mem [lfu_pkg::DEPTH];
  lfu_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/lfu_scan.sv
// Shared compare unit that walks the entries for key match, victim and free slot.
module lfu_scan (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      clr,
  input  logic                      en,
  input  logic [lfu_pkg::IDX_W-1:0] idx,
  input  logic                      vld,
  input  lfu_pkg::entry_t           ent,
  input  logic [lfu_pkg::KEY_W-1:0] key,
  output lfu_pkg::scan_res_t        res
);

  localparam int RANK_W = lfu_pkg::COUNT_W + lfu_pkg::STAMP_W;

  logic                        m_found_r;
  logic [lfu_pkg::IDX_W-1:0]   m_idx_r;
  logic [lfu_pkg::COUNT_W-1:0] m_count_r;
  logic                        v_found_r;
  logic [lfu_pkg::IDX_W-1:0]   v_idx_r;
  logic [RANK_W-1:0]           v_rank_r;
  logic                        f_found_r;
  logic [lfu_pkg::IDX_W-1:0]   f_idx_r;

  logic [RANK_W-1:0] rank;
  logic              key_eq;
  logic              better;

  assign rank   = {ent.count, ent.stamp};
  assign key_eq = (ent.key == key);
  assign better = !v_found_r || (rank < v_rank_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_found_r <= 1'b0;
      v_found_r <= 1'b0;
      f_found_r <= 1'b0;
    end else if (clr) begin
      m_found_r <= 1'b0;
      v_found_r <= 1'b0;
      f_found_r <= 1'b0;
    end else if (en) begin
      if (vld) begin
        if (key_eq && !m_found_r) begin
          m_found_r <= 1'b1;
          m_idx_r   <= idx;
          m_count_r <= ent.count;
        end
        if (better) begin
          v_found_r <= 1'b1;
          v_idx_r   <= idx;
          v_rank_r  <= rank;
        end
      end else if (!f_found_r) begin
        f_found_r <= 1'b1;
        f_idx_r   <= idx;
      end
    end
  end

  always_comb begin
    res.m_found = m_found_r;
    res.m_idx   = m_idx_r;
    res.m_count = m_count_r;
    res.v_found = v_found_r;
    res.v_idx   = v_idx_r;
    res.f_found = f_found_r;
    res.f_idx   = f_idx_r;
  end

endmodule
